// ===== src/assert_macros.svh =====
// Assertion macros for the striped top-k selector.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge outside reset.
`define SVA_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SVA_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SVA_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/stk_pkg.sv =====
// Shared types, constants and the score ordering key for the top-k selector.
// No dependencies.
package stk_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 32;
  localparam int unsigned MAX_CHUNKS_DEF  = 64;

  localparam int unsigned SCORE_W    = 32;
  localparam int unsigned INDEX_W    = 22;
  localparam int unsigned CHUNK_W    = 6;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned TOKEN_W    = 32;
  localparam int unsigned CAP_W      = 6;
  localparam int unsigned CLEN_W     = 17;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CAP_W-1:0]   CAPACITY_RST  = CAP_W'(32);
  localparam logic [CLEN_W-1:0]  CHUNK_LEN_RST = CLEN_W'(1);
  localparam logic [TOKEN_W-1:0] END_TOKEN_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY  = 2'd0,
    CFG_CHUNK_LEN = 2'd1,
    CFG_END_TOKEN = 2'd2
  } cfg_reg_e;

  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [INDEX_W-1:0] index;
  } entry_t;

  typedef struct packed {
    logic insert;  // offer transfer that enters the chain
    logic rotate;  // readout step
    logic held;    // cell lies below the fill count
    logic tail;    // cell is the last held one
  } cell_ctl_t;

  // Monotone unsigned key of a float bit pattern; minus zero maps to plus zero.
  function automatic logic [SCORE_W-1:0] score_key(input logic [SCORE_W-1:0] s);
    logic [SCORE_W-1:0] t;
    t = (s == {1'b1, {(SCORE_W-1){1'b0}}}) ? '0 : s;
    return t[SCORE_W-1] ? ~t : (t | {1'b1, {(SCORE_W-1){1'b0}}});
  endfunction

endpackage

// ===== src/stk_cell.sv =====
// One cell of the sorted chain: holds one entry, compares it with the offered
// candidate and takes its neighbor's entry on insert or rotate. Uses stk_pkg.
module stk_cell (
  input  logic                        clk_i,
  input  stk_pkg::cell_ctl_t          ctl_i,
  input  stk_pkg::entry_t             new_entry_i,
  input  logic [stk_pkg::SCORE_W-1:0] new_key_i,
  input  logic                        prev_above_i,
  input  stk_pkg::entry_t             prev_entry_i,
  input  stk_pkg::entry_t             next_entry_i,
  input  stk_pkg::entry_t             head_entry_i,
  output stk_pkg::entry_t             entry_o,
  output logic                        above_o,
  output logic                        key_gt_o
);

  stk_pkg::entry_t             entry_q, entry_d;
  logic [stk_pkg::SCORE_W-1:0] cell_key;

  assign cell_key = stk_pkg::score_key(entry_q.score);

  // held entry ranks strictly above the candidate (lower index is smaller on ties)
  assign above_o = ctl_i.held &&
                   ((cell_key > new_key_i) ||
                    ((cell_key == new_key_i) && (new_entry_i.index < entry_q.index)));
  assign key_gt_o = new_key_i > cell_key;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.insert) begin
      if (!above_o) begin
        entry_d = prev_above_i ? new_entry_i : prev_entry_i;
      end
    end else if (ctl_i.rotate && ctl_i.held) begin
      entry_d = ctl_i.tail ? head_entry_i : next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== src/stk_chunk_flags.sv =====
// Per-chunk active flags with batch restart and clear on a dropped candidate.
// Uses stk_pkg for the chunk field width.
module stk_chunk_flags #(
  parameter int unsigned MaxChunks = stk_pkg::MAX_CHUNKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        clear_i,
  input  logic [stk_pkg::CHUNK_W-1:0] chunk_i,
  output logic                        active_o
);

  logic [MaxChunks-1:0] flags_q, flags_d;
  logic [MaxChunks-1:0] hit;

  // no hit for a chunk number beyond the flag row, so it reads inactive
  always_comb begin
    for (int c = 0; c < int'(MaxChunks); c++) begin
      hit[c] = (int'(chunk_i) == c);
    end
  end

  assign active_o = start_i ? (|hit) : (|(hit & flags_q));

  always_comb begin
    flags_d = start_i ? '1 : flags_q;
    if (clear_i) begin
      flags_d = flags_d & ~hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '1;
    end else begin
      flags_q <= flags_d;
    end
  end

endmodule

// ===== src/striped_top_k_selector.sv =====
// Offer: result registered in the cycle after the input transfer; one offer per cycle while
//   the input is not stalled. Readout: first entry via the busy flag and the output register,
//   then one per cycle while the output is not stalled; input stalls until the last entry is
//   loaded, the chain rotating once per emitted entry. Empty readout answers like an offer.
// Reset: count 0, all chunks active, registers at defaults; entries are not cleared.
`include "assert_macros.svh"

module striped_top_k_selector #(
  parameter int unsigned MAX_ENTRIES = stk_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned MAX_CHUNKS  = stk_pkg::MAX_CHUNKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [stk_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stk_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic                           start_batch_i,
  input  logic [stk_pkg::CHUNK_W-1:0]    chunk_i,
  input  logic [stk_pkg::POS_W-1:0]      position_i,
  input  logic [stk_pkg::SCORE_W-1:0]    score_i,
  input  logic [stk_pkg::TOKEN_W-1:0]    token_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           inserted_o,
  output logic                           chunk_active_o,
  output logic [stk_pkg::COUNT_W-1:0]    count_o,
  output logic                           entry_valid_o,
  output logic [stk_pkg::SCORE_W-1:0]    out_score_o,
  output logic [stk_pkg::INDEX_W-1:0]    out_index_o,
  output logic                           last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // configuration registers
  logic [stk_pkg::CAP_W-1:0]   cap_q;
  logic [stk_pkg::CLEN_W-1:0]  chunk_len_q;
  logic [stk_pkg::TOKEN_W-1:0] end_tok_q;

  // control
  logic [CNT_W-1:0] count_q, count_d;
  logic             rd_busy_q, rd_busy_d;
  logic [CNT_W-1:0] rd_left_q, rd_left_d;
  logic             out_valid_q, out_valid_d;

  // result payload
  logic                        inserted_q, inserted_d;
  logic                        chunk_act_q, chunk_act_d;
  logic [stk_pkg::COUNT_W-1:0] count_out_q, count_out_d;
  logic                        entry_valid_q, entry_valid_d;
  logic [stk_pkg::SCORE_W-1:0] score_out_q, score_out_d;
  logic [stk_pkg::INDEX_W-1:0] index_out_q, index_out_d;
  logic                        last_q, last_d;

  logic out_free, in_xfer, offer, read_req, read_empty, emit;
  logic active, is_end, full, evict_ok, do_ins, drop;
  logic [6:0]  eff_cap;
  logic [stk_pkg::CLEN_W+stk_pkg::CHUNK_W-1:0] index_full;
  logic [stk_pkg::SCORE_W-1:0] new_key;
  stk_pkg::entry_t             new_entry;
  logic [IDX_W-1:0]            tail_idx;

  stk_pkg::entry_t    cell_q     [MAX_ENTRIES];
  stk_pkg::entry_t    prev_entry [MAX_ENTRIES];
  stk_pkg::entry_t    next_entry [MAX_ENTRIES];
  stk_pkg::cell_ctl_t ctl        [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] above, prev_above, key_gt;

  // ---------------------------------------------------------------- handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = rd_busy_q || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign offer      = in_xfer && (func_i != stk_pkg::FUNC_READ);
  assign read_req   = in_xfer && (func_i == stk_pkg::FUNC_READ);
  assign read_empty = read_req && (count_q == '0);
  assign emit       = rd_busy_q && out_free;

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------- candidate
  assign index_full = (stk_pkg::CLEN_W + stk_pkg::CHUNK_W)'(chunk_i) *
                      (stk_pkg::CLEN_W + stk_pkg::CHUNK_W)'(chunk_len_q) +
                      (stk_pkg::CLEN_W + stk_pkg::CHUNK_W)'(position_i);
  assign new_entry.score = score_i;
  assign new_entry.index = stk_pkg::INDEX_W'(index_full);
  assign new_key         = stk_pkg::score_key(score_i);

  stk_chunk_flags #(
    .MaxChunks (MAX_CHUNKS)
  ) u_flags (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (offer && start_batch_i),
    .clear_i  (drop),
    .chunk_i  (chunk_i),
    .active_o (active)
  );

  // capacity 0 acts as 1, above the chain length as the chain length
  always_comb begin
    eff_cap = {1'b0, cap_q};
    if (cap_q == '0) begin
      eff_cap = 7'd1;
    end else if ({1'b0, cap_q} > 7'(MAX_ENTRIES)) begin
      eff_cap = 7'(MAX_ENTRIES);
    end
  end

  assign full     = 7'(count_q) >= eff_cap;
  assign tail_idx = IDX_W'(count_q - CNT_W'(1));
  assign evict_ok = key_gt[tail_idx];
  assign is_end   = token_i == end_tok_q;
  assign do_ins   = offer && active && !is_end && (!full || evict_ok);
  assign drop     = offer && active && !is_end && full && !evict_ok;

  // ---------------------------------------------------------------- cell chain
  // Descending order: cell 0 holds the largest entry. On a full insert the
  // last held entry shifts past the fill count and is gone.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_above[i] = 1'b1;
      assign prev_entry[i] = new_entry;
    end else begin : g_mid
      assign prev_above[i] = above[i-1];
      assign prev_entry[i] = cell_q[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_end
      assign next_entry[i] = cell_q[i];
    end else begin : g_inner
      assign next_entry[i] = cell_q[i+1];
    end

    assign ctl[i] = '{insert: do_ins,
                      rotate: emit,
                      held:   CNT_W'(i) < count_q,
                      tail:   CNT_W'(i + 1) == count_q};

    stk_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl[i]),
      .new_entry_i  (new_entry),
      .new_key_i    (new_key),
      .prev_above_i (prev_above[i]),
      .prev_entry_i (prev_entry[i]),
      .next_entry_i (next_entry[i]),
      .head_entry_i (cell_q[0]),
      .entry_o      (cell_q[i]),
      .above_o      (above[i]),
      .key_gt_o     (key_gt[i])
    );
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    count_d   = count_q;
    rd_busy_d = rd_busy_q;
    rd_left_d = rd_left_q;
    if (do_ins && !full) begin
      count_d = count_q + CNT_W'(1);
    end
    if (read_req && (count_q != '0)) begin
      rd_busy_d = 1'b1;
      rd_left_d = count_q;
    end
    if (emit) begin
      rd_left_d = rd_left_q - CNT_W'(1);
      if (rd_left_q == CNT_W'(1)) begin
        rd_busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d   = out_valid_q && out_stall_i;
    inserted_d    = inserted_q;
    chunk_act_d   = chunk_act_q;
    count_out_d   = count_out_q;
    entry_valid_d = entry_valid_q;
    score_out_d   = score_out_q;
    index_out_d   = index_out_q;
    last_d        = last_q;
    if (offer || read_empty) begin
      out_valid_d   = 1'b1;
      inserted_d    = do_ins;
      chunk_act_d   = offer && active && !drop;
      count_out_d   = offer ? stk_pkg::COUNT_W'(count_d) : '0;
      entry_valid_d = 1'b0;
      score_out_d   = '0;
      index_out_d   = '0;
      last_d        = 1'b1;
    end else if (emit) begin
      out_valid_d   = 1'b1;
      inserted_d    = 1'b0;
      chunk_act_d   = 1'b0;
      count_out_d   = stk_pkg::COUNT_W'(count_q);
      entry_valid_d = 1'b1;
      score_out_d   = cell_q[0].score;
      index_out_d   = cell_q[0].index;
      last_d        = rd_left_q == CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= stk_pkg::CAPACITY_RST;
      chunk_len_q <= stk_pkg::CHUNK_LEN_RST;
      end_tok_q   <= stk_pkg::END_TOKEN_RST;
      count_q     <= '0;
      rd_busy_q   <= 1'b0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          stk_pkg::CFG_CAPACITY:  cap_q       <= stk_pkg::CAP_W'(cfg_data_i);
          stk_pkg::CFG_CHUNK_LEN: chunk_len_q <= stk_pkg::CLEN_W'(cfg_data_i);
          stk_pkg::CFG_END_TOKEN: end_tok_q   <= cfg_data_i;
          default: ;
        endcase
      end
      count_q     <= count_d;
      rd_busy_q   <= rd_busy_d;
      rd_left_q   <= rd_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inserted_q    <= inserted_d;
    chunk_act_q   <= chunk_act_d;
    count_out_q   <= count_out_d;
    entry_valid_q <= entry_valid_d;
    score_out_q   <= score_out_d;
    index_out_q   <= index_out_d;
    last_q        <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign inserted_o     = inserted_q;
  assign chunk_active_o = chunk_act_q;
  assign count_o        = count_out_q;
  assign entry_valid_o  = entry_valid_q;
  assign out_score_o    = score_out_q;
  assign out_index_o    = index_out_q;
  assign last_o         = last_q;

  // ---------------------------------------------------------------- assertions
  `SVA_ALWAYS(a_count_bound, count_q <= CNT_W'(MAX_ENTRIES), "fill count beyond chain length")
  `SVA_NEXT(a_rd_count_stable, rd_busy_q, count_q == $past(count_q), "count moved in readout")
  `SVA_IMPLY(a_empty_is_last, out_valid_o && !entry_valid_o, last_o, "plain result not last")
  if (MAX_ENTRIES > 1) begin : g_sort_chk
    `SVA_IMPLY(a_chain_sorted, !rd_busy_q && (count_q >= CNT_W'(2)), stk_pkg::score_key(cell_q[0].score) >= stk_pkg::score_key(cell_q[1].score), "chain head out of order")
  end

endmodule
